>>> design/ffbp_pkg.sv
// First-fit bin packer: shared types and constants.
// Used by ffbp_cell and first_fit_bin_packer_top; depends on nothing.
package ffbp_pkg;

   localparam int unsigned SIZE_W      = 16;
   localparam int unsigned BIN_INDEX_W = 6;
   localparam int unsigned BINS_USED_W = 7;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [SIZE_W-1:0] CAP_RESET = 16'd100;
   localparam logic [SIZE_W-1:0] FULL_MARK = 16'hFFFF;

   // register index = paddr[2]
   localparam logic REG_BIN_CAPACITY = 1'b0;

   // control flags of an item travelling down the chain
   typedef struct packed {
      logic valid;
      logic clear;   // empty every bin before placing
      logic over;    // size above capacity
      logic placed;  // some bin already took the item
      logic opened;  // placement opened a bin
   } tok_ctl_type;

endpackage

>>> design/ffbp_cell.sv
// One bin of the first-fit chain: holds fill and open flag, passes the item on.
// Depends on ffbp_pkg.
module ffbp_cell #(
   parameter int unsigned IDX_W   = 6,
   parameter int unsigned CNT_W   = 7,
   parameter int unsigned CELL_ID = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [ffbp_pkg::SIZE_W-1:0] capacity,
   input  ffbp_pkg::tok_ctl_type       ctl_i,
   input  logic [ffbp_pkg::SIZE_W-1:0] size_i,
   input  logic [IDX_W-1:0]            idx_i,
   input  logic [CNT_W-1:0]            cnt_i,
   output ffbp_pkg::tok_ctl_type       ctl_o,
   output logic [ffbp_pkg::SIZE_W-1:0] size_o,
   output logic [IDX_W-1:0]            idx_o,
   output logic [CNT_W-1:0]            cnt_o
);
   import ffbp_pkg::*;

   logic              open_ff, open_in;
   logic [SIZE_W-1:0] fill_ff, fill_in;
   tok_ctl_type       ctl_ff, ctl_in;
   logic [SIZE_W-1:0] size_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic open_eff, fits, take_fit, take_new;

   always_comb begin
      open_eff = open_ff & ~ctl_i.clear;
      fits     = open_eff &&
                 ({1'b0, fill_ff} + {1'b0, size_i} <= {1'b0, capacity});
      take_fit = ctl_i.valid & ~ctl_i.placed & fits;
      take_new = ctl_i.valid & ~ctl_i.placed & ~open_eff;

      open_in = open_ff;
      fill_in = fill_ff;
      if (ctl_i.valid) begin
         open_in = open_eff | take_new;
      end
      if (take_fit) begin
         fill_in = fill_ff + size_i;
      end else if (take_new) begin
         fill_in = ctl_i.over ? FULL_MARK : size_i;
      end

      ctl_in        = ctl_i;
      ctl_in.placed = ctl_i.placed | take_fit | take_new;
      ctl_in.opened = ctl_i.opened | take_new;
      idx_in        = (take_fit | take_new) ? IDX_W'(CELL_ID) : idx_i;
      cnt_in        = cnt_i + CNT_W'(open_eff | take_new);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         ctl_ff  <= '0;
      end else if (advance) begin
         open_ff <= open_in;
         ctl_ff  <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fill_ff <= fill_in;
         size_ff <= size_i;
         idx_ff  <= idx_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign ctl_o  = ctl_ff;
   assign size_o = size_ff;
   assign idx_o  = idx_ff;
   assign cnt_o  = cnt_ff;

endmodule

>>> design/first_fit_bin_packer_top.sv
// First-fit bin packer, top level: config register, chain of bin cells, result.
// Depends on ffbp_pkg and ffbp_cell.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  req     | in        | req_valid/req_stall  | item_size, first_item
//  rsp     | out       | rsp_valid/rsp_stall  | bin_index, opened_new, bins_used,
//          |           |                      | no_room, oversize
//  csr     | in/out    | psel/penable/pready  | bin_capacity at byte address 0
//
// Each item walks the chain one bin per cycle while the chain advances, passing
// every cell register in order from acceptance to rsp_valid; items enter back to
// back, one per cycle while req_stall is low, because they keep their order
// through the cells. The last cell's token register is the result register.
// rsp_stall while a result waits at the tail freezes the whole chain and raises
// req_stall. Reset (synchronous) closes every bin and sets capacity to 100.
module first_fit_bin_packer_top #(
   parameter int unsigned MAX_BINS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // item input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ffbp_pkg::SIZE_W-1:0]     req_item_size,
   input  logic                            req_first_item,
   // result output
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ffbp_pkg::BIN_INDEX_W-1:0] rsp_bin_index,
   output logic                            rsp_opened_new,
   output logic [ffbp_pkg::BINS_USED_W-1:0] rsp_bins_used,
   output logic                            rsp_no_room,
   output logic                            rsp_oversize,
   // configuration
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ffbp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ffbp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ffbp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import ffbp_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_BINS);
   localparam int unsigned CNT_W = $clog2(MAX_BINS + 1);

   // ---- configuration register ----
   logic [SIZE_W-1:0] cap_ff, cap_in;
   logic              cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & (paddr[2] == REG_BIN_CAPACITY);

   always_comb begin
      cap_in = cap_ff;
      if (cfg_write) begin
         cap_in = pwdata[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // low two address bits are byte offsets and are ignored
   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_BIN_CAPACITY) begin
         prdata = {{(CSR_DATA_W-SIZE_W){1'b0}}, cap_ff};
      end
   end

   // ---- cell chain ----
   tok_ctl_type       ctl_c  [0:MAX_BINS];
   logic [SIZE_W-1:0] size_c [0:MAX_BINS];
   logic [IDX_W-1:0]  idx_c  [0:MAX_BINS];
   logic [CNT_W-1:0]  cnt_c  [0:MAX_BINS];
   logic              advance;

   // the chain moves unless a finished result sits unaccepted at the tail
   assign advance   = ~(ctl_c[MAX_BINS].valid & rsp_stall);
   assign req_stall = ~advance;

   // item enters with nothing placed; oversize is judged once, up front
   always_comb begin
      ctl_c[0].valid  = req_valid;
      ctl_c[0].clear  = req_first_item;
      ctl_c[0].over   = req_item_size > cap_ff;
      ctl_c[0].placed = 1'b0;
      ctl_c[0].opened = 1'b0;
      size_c[0]       = req_item_size;
      idx_c[0]        = '0;
      cnt_c[0]        = '0;
   end

   for (genvar j = 0; j < MAX_BINS; j++) begin : g_cell
      ffbp_cell #(
         .IDX_W   (IDX_W),
         .CNT_W   (CNT_W),
         .CELL_ID (j)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .capacity (cap_ff),
         .ctl_i    (ctl_c[j]),
         .size_i   (size_c[j]),
         .idx_i    (idx_c[j]),
         .cnt_i    (cnt_c[j]),
         .ctl_o    (ctl_c[j+1]),
         .size_o   (size_c[j+1]),
         .idx_o    (idx_c[j+1]),
         .cnt_o    (cnt_c[j+1])
      );
   end

   // ---- result: tail token register ----
   // index reported modulo 64, count modulo 128
   logic [IDX_W+BIN_INDEX_W-1:0] idx_ext;
   logic [CNT_W+BINS_USED_W-1:0] cnt_ext;
   tok_ctl_type                  tail;

   assign tail    = ctl_c[MAX_BINS];
   assign idx_ext = {{BIN_INDEX_W{1'b0}}, idx_c[MAX_BINS]};
   assign cnt_ext = {{BINS_USED_W{1'b0}}, cnt_c[MAX_BINS]};

   assign rsp_valid      = tail.valid;
   assign rsp_bin_index  = idx_ext[BIN_INDEX_W-1:0];
   assign rsp_opened_new = tail.opened;
   assign rsp_bins_used  = cnt_ext[BINS_USED_W-1:0];
   assign rsp_no_room    = ~tail.placed;
   assign rsp_oversize   = tail.over;

   // ---- checks ----
   a_drop_not_opened: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_room |-> !rsp_opened_new && rsp_bin_index == '0)
      else $error("dropped item reports a bin");

   a_drop_all_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_room |-> cnt_c[MAX_BINS] == CNT_W'(MAX_BINS))
      else $error("item dropped while a bin was still free");

   a_open_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_opened_new |->
         rsp_bins_used[BIN_INDEX_W-1:0] == rsp_bin_index + 1'b1)
      else $error("new bin is not the last open bin");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> cnt_c[MAX_BINS] == $past(cnt_c[MAX_BINS]))
      else $error("tail count moved under stall");

endmodule
